// ===== rtl/core/wmma_pkg.sv =====
// shared constants and types for the four-channel window min/max/average block
package wmma_pkg;

  localparam int unsigned ChanCount = 4;
  localparam int unsigned InWidth   = 16;
  localparam int unsigned OutWidth  = 16;
  localparam int unsigned InTdataW  = ChanCount * InWidth;
  localparam int unsigned OutTdataW = ChanCount * 3 * OutWidth;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StStart,
    StDivide,
    StHold
  } wmma_state_e;

endpackage

// ===== rtl/core/window_min_max_average_four_channel.sv =====
// top level: ring memory of samples, scan for min/max/sum and per-channel dividers
//
// Input stream (s_axis): one word per sample, four 16-bit readings in tdata.
// Output stream (m_axis): one word per sample with min, max and truncated
// average of each channel over the samples held in the ring.
// Each accepted sample is written to the ring at the write position, then the
// ring is read one entry per cycle from slot 0 up to the fill count, and the
// four channel sums are divided by the fill count in four bit-serial dividers.
// The result waits for the scan of the ring and then for the dividers; the
// next sample is taken once the result has gone into the output register
// and the block is back in idle.
// One sample is in work at a time; s_axis_tready is high while the block
// waits for a sample, also while a finished result still waits in the output
// register. If the receiver stalls with a result pending, a second result
// waits inside the block and input is held off until the output frees up.
// Reset clears write position, fill count and handshakes; ring contents are
// not cleared, as only written slots are ever read.
module window_min_max_average_four_channel #(
  parameter int unsigned WINDOW_DEPTH = 32,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // speed_sample, heart_sample, cadence_sample, power_sample
  input  logic [wmma_pkg::InTdataW-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // speed_min, speed_max, speed_mean, heart_min, heart_max, heart_mean,
  // cadence_min, cadence_max, cadence_mean, power_min, power_max, power_mean
  output logic [wmma_pkg::OutTdataW-1:0]  m_axis_tdata
);

  localparam int unsigned Chan  = wmma_pkg::ChanCount;
  localparam int unsigned Sw    = SAMPLE_WIDTH;
  localparam int unsigned CntW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned AddrW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned SumW  = Sw + CntW;
  localparam int unsigned OutW  = wmma_pkg::OutWidth;
  localparam int unsigned InW   = wmma_pkg::InWidth;

  wmma_pkg::wmma_state_e state_q, state_d;

  logic [AddrW-1:0]  wpos_q, wpos_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [CntW-1:0]   rcnt_q, rcnt_d;
  logic              rd_en;
  logic              rv_q;
  logic              in_acc;
  logic              acc_init;
  logic              load_out;
  logic              out_free;
  logic              div_start;
  logic [Chan-1:0]   div_busy_v;
  logic              div_busy;
  logic              mvalid_q, mvalid_d;

  logic [Chan*Sw-1:0] mem [WINDOW_DEPTH];
  logic [Chan*Sw-1:0] wdata;
  logic [Chan*Sw-1:0] rdata_q;

  logic [Sw-1:0]    lo_q  [Chan];
  logic [Sw-1:0]    hi_q  [Chan];
  logic [SumW-1:0]  sum_q [Chan];
  logic [SumW-1:0]  quo   [Chan];

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !mvalid_q || m_axis_tready;

  genvar gc;
  generate
    for (gc = 0; gc < Chan; gc++) begin : g_in
      assign wdata[gc*Sw +: Sw] = Sw'(s_axis_tdata[gc*InW +: InW]);
    end
  endgenerate

  // ring memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem[wpos_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rcnt_q[AddrW-1:0]];
    end
  end

  always_comb begin
    state_d   = state_q;
    wpos_d    = wpos_q;
    fill_d    = fill_q;
    rcnt_d    = rcnt_q;
    rd_en     = 1'b0;
    acc_init  = 1'b0;
    load_out  = 1'b0;
    div_start = 1'b0;
    mvalid_d  = mvalid_q;
    s_axis_tready = (state_q == wmma_pkg::StIdle);

    if (mvalid_q && m_axis_tready) begin
      mvalid_d = 1'b0;
    end

    case (state_q)
      wmma_pkg::StIdle: begin
        if (in_acc) begin
          wpos_d   = (wpos_q == AddrW'(WINDOW_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
          fill_d   = (fill_q == CntW'(WINDOW_DEPTH)) ? fill_q : fill_q + 1'b1;
          rcnt_d   = '0;
          acc_init = 1'b1;
          state_d  = wmma_pkg::StScan;
        end
      end
      wmma_pkg::StScan: begin
        rd_en  = 1'b1;
        rcnt_d = rcnt_q + 1'b1;
        if (rcnt_q + 1'b1 == fill_q) begin
          state_d = wmma_pkg::StDrain;
        end
      end
      wmma_pkg::StDrain: begin
        state_d = wmma_pkg::StStart;
      end
      wmma_pkg::StStart: begin
        div_start = 1'b1;
        state_d   = wmma_pkg::StDivide;
      end
      wmma_pkg::StDivide: begin
        if (!div_busy) begin
          if (out_free) begin
            load_out = 1'b1;
            mvalid_d = 1'b1;
            state_d  = wmma_pkg::StIdle;
          end else begin
            state_d  = wmma_pkg::StHold;
          end
        end
      end
      wmma_pkg::StHold: begin
        if (out_free) begin
          load_out = 1'b1;
          mvalid_d = 1'b1;
          state_d  = wmma_pkg::StIdle;
        end
      end
      default: begin
        state_d = wmma_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wmma_pkg::StIdle;
      wpos_q   <= '0;
      fill_q   <= '0;
      rcnt_q   <= '0;
      rv_q     <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wpos_q   <= wpos_d;
      fill_q   <= fill_d;
      rcnt_q   <= rcnt_d;
      rv_q     <= rd_en;
      mvalid_q <= mvalid_d;
    end
  end

  // per-channel min, max and sum over the scanned entries
  generate
    for (gc = 0; gc < Chan; gc++) begin : g_acc
      logic [Sw-1:0] v;
      assign v = rdata_q[gc*Sw +: Sw];

      always_ff @(posedge clk_i) begin
        if (acc_init) begin
          lo_q[gc]  <= '1;
          hi_q[gc]  <= '0;
          sum_q[gc] <= '0;
        end else if (rv_q) begin
          if (v < lo_q[gc]) begin
            lo_q[gc] <= v;
          end
          if (v > hi_q[gc]) begin
            hi_q[gc] <= v;
          end
          sum_q[gc] <= sum_q[gc] + SumW'(v);
        end
      end

      wmma_div #(
        .NumWidth (SumW),
        .DenWidth (CntW)
      ) u_div (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .start_i (div_start),
        .num_i   (sum_q[gc]),
        .den_i   (fill_q),
        .busy_o  (div_busy_v[gc]),
        .quo_o   (quo[gc])
      );
    end
  endgenerate

  assign div_busy = |div_busy_v;

  // output word register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int i = 0; i < Chan; i++) begin
        m_axis_tdata[(i*3)*OutW +: OutW]     <= OutW'(lo_q[i]);
        m_axis_tdata[(i*3 + 1)*OutW +: OutW] <= OutW'(hi_q[i]);
        m_axis_tdata[(i*3 + 2)*OutW +: OutW] <= OutW'(quo[i]);
      end
    end
  end

  assign m_axis_tvalid = mvalid_q;

endmodule

// ===== rtl/core/wmma_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module wmma_div #(
  parameter int unsigned NumWidth = 21,
  parameter int unsigned DenWidth = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumWidth-1:0] num_i,
  input  logic [DenWidth-1:0] den_i,
  output logic                busy_o,
  output logic [NumWidth-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumWidth + 1);

  logic [DenWidth-1:0] rem_q, rem_d;
  logic [NumWidth-1:0] quo_q, quo_d;
  logic [DenWidth-1:0] den_q, den_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [DenWidth:0]   trial;
  logic [DenWidth:0]   diff;

  assign trial = {rem_q, quo_q[NumWidth-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = CntW'(NumWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[DenWidth-1:0];
        quo_d = {quo_q[NumWidth-2:0], 1'b1};
      end else begin
        rem_d = trial[DenWidth-1:0];
        quo_d = {quo_q[NumWidth-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== sim/window_min_max_average_four_channel_tb.sv =====
// testbench for the four-channel sliding window min/max/average block
`timescale 1ns / 100ps

module window_min_max_average_four_channel_tb;

  localparam int unsigned ChanCount   = wmma_pkg::ChanCount;
  localparam int unsigned InWidth     = wmma_pkg::InWidth;
  localparam int unsigned OutWidth    = wmma_pkg::OutWidth;
  localparam int unsigned InTdataW    = wmma_pkg::InTdataW;
  localparam int unsigned OutTdataW   = wmma_pkg::OutTdataW;
  localparam int unsigned WinDepth    = 32;
  localparam int unsigned StatFields  = ChanCount * 3;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned PhaseItems  = 270;

  class window_stats_checker;
    logic [InWidth-1:0]   ring [WinDepth][ChanCount];
    int unsigned          wr_slot;
    int unsigned          held;
    logic [OutTdataW-1:0] expected_stats [$];
    int unsigned          mismatches;
    int unsigned          results_seen;

    function new();
      wr_slot      = 0;
      held         = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void note_sample(logic [InTdataW-1:0] w);
      logic [OutTdataW-1:0] stats;
      int unsigned lo, hi, sum, v;
      for (int unsigned ch = 0; ch < ChanCount; ch++) begin
        ring[wr_slot][ch] = w[ch*InWidth +: InWidth];
      end
      wr_slot = (wr_slot == WinDepth - 1) ? 0 : wr_slot + 1;
      if (held < WinDepth) begin
        held++;
      end
      for (int unsigned ch = 0; ch < ChanCount; ch++) begin
        lo  = 32'h0000_ffff;
        hi  = 0;
        sum = 0;
        for (int unsigned k = 0; k < held; k++) begin
          v = ring[k][ch];
          if (v < lo) lo = v;
          if (v > hi) hi = v;
          sum += v;
        end
        stats[(3*ch)*OutWidth   +: OutWidth] = lo[OutWidth-1:0];
        stats[(3*ch+1)*OutWidth +: OutWidth] = hi[OutWidth-1:0];
        stats[(3*ch+2)*OutWidth +: OutWidth] = OutWidth'(sum / held);
      end
      expected_stats.push_back(stats);
    endfunction

    function void check_result(logic [OutTdataW-1:0] got);
      logic [OutTdataW-1:0] want;
      if (expected_stats.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result word %h", got);
        end
        mismatches++;
        return;
      end
      want = expected_stats.pop_front();
      for (int unsigned f = 0; f < StatFields; f++) begin
        if (got[f*OutWidth +: OutWidth] !== want[f*OutWidth +: OutWidth]) begin
          if (mismatches < 10) begin
            $display("result %0d channel %0d stat %0d: expected %h got %h", results_seen,
                     f / 3, f % 3, want[f*OutWidth +: OutWidth],
                     got[f*OutWidth +: OutWidth]);
          end
          mismatches++;
        end
      end
      results_seen++;
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  window_stats_checker stats_chk = new();

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  window_min_max_average_four_channel #(
    .WINDOW_DEPTH(WinDepth),
    .SAMPLE_WIDTH(InWidth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // result side: check, then pick next tready
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      stats_chk.check_result(m_axis_tdata);
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL window_min_max_average_four_channel");
      $finish;
    end
  end

  function automatic logic [InTdataW-1:0] pack(logic [15:0] spd, logic [15:0] hrt,
                                                 logic [15:0] cad, logic [15:0] pwr);
    return {pwr, cad, hrt, spd};
  endfunction

  function automatic logic [15:0] rand_reading();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(15));
      3: return 16'hfff0 | 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [InTdataW-1:0] rand_sample();
    return pack(rand_reading(), rand_reading(), rand_reading(), rand_reading());
  endfunction

  task automatic send_sample(input logic [InTdataW-1:0] w);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    stats_chk.note_sample(w);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (stats_chk.expected_stats.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes and bit patterns while the window fills
    send_sample(pack(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(pack(16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_sample(pack(16'h0000, 16'hffff, 16'h0000, 16'hffff));
    send_sample(pack(16'hffff, 16'h0000, 16'hffff, 16'h0000));
    send_sample(pack(16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
    send_sample(pack(16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    send_sample(pack(16'h0001, 16'hfffe, 16'h8000, 16'h7fff));
    for (int i = 0; i < 16; i++) begin
      send_sample(pack(16'h1 << i, ~(16'h1 << i), 16'h1 << ((i + 4) % 16),
                       ~(16'h1 << ((i + 8) % 16))));
    end
    wait_drained();

    // long output stall with input still offered
    hold_req     <= hold_req + 1;
    src_idle_pct  = 0;
    repeat (12) send_sample(rand_sample());
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
        default: begin src_idle_pct = 34; sink_stall_pct = 34; end
      endcase
      repeat (PhaseItems) send_sample(rand_sample());
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (stats_chk.mismatches == 0 && stats_chk.expected_stats.size() == 0) begin
      $display("PASS window_min_max_average_four_channel");
    end else begin
      $display("FAIL window_min_max_average_four_channel");
    end
    $finish;
  end

endmodule

// ===== window_min_max_average_four_channel.f =====
rtl/core/wmma_pkg.sv
rtl/core/wmma_div.sv
rtl/core/window_min_max_average_four_channel.sv
sim/window_min_max_average_four_channel_tb.sv
